// ===== rtl/aging_priority_scheduler_assert.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef AGING_PRIORITY_SCHEDULER_ASSERT_SVH
`define AGING_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define APS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define APS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aps_pkg.sv =====
// Package with shared types, codes and helper functions of the scheduler.
`timescale 1ns / 1ps

package aps_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SCHED  = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NONE      = 2'd3;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] aging;
    logic signed [15:0] next_prio;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_AGE,
    CELL_HEAD
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_AGE,
    S_POST
  } sched_state_t;

  function automatic logic signed [15:0] sat_inc(input logic signed [15:0] v);
    return (v == 16'sh7FFF) ? v : v + 16'sd1;
  endfunction

  function automatic logic signed [15:0] sat_dec(input logic signed [15:0] v);
    return (v == -16'sh8000) ? v : v - 16'sd1;
  endfunction

endpackage

// ===== rtl/aps_in_if.sv =====
// Request channel interface of the scheduler.
`timescale 1ns / 1ps

interface aps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         proc_id;
  logic signed [15:0] priority_req;

  modport source (output valid, output req_type, output proc_id, output priority_req,
                  input ready);
  modport sink (input valid, input req_type, input proc_id, input priority_req,
                output ready);
endinterface

// ===== rtl/aps_out_if.sv =====
// Result channel interface of the scheduler.
`timescale 1ns / 1ps

interface aps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] chosen_id;

  modport source (output valid, output status, output chosen_id, input ready);
  modport sink (input valid, input status, input chosen_id, output ready);
endinterface

// ===== rtl/aps_cfg_if.sv =====
// Configuration write channel interface of the scheduler.
`timescale 1ns / 1ps

interface aps_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] realtime_priority;

  modport source (output valid, output realtime_priority, input ready);
  modport sink (input valid, input realtime_priority, output ready);
endinterface

// ===== rtl/aps_cell.sv =====
// One table cell that holds a scheduler entry and trades it with its neighbors.
`timescale 1ns / 1ps

module aps_cell (
  input  logic              clk,
  input  aps_pkg::cell_op_t op,
  input  aps_pkg::entry_t   left_in,
  input  aps_pkg::entry_t   right_in,
  input  aps_pkg::entry_t   load_in,
  output aps_pkg::entry_t   entry_o
);
  import aps_pkg::*;

  entry_t ent_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:       ent_r <= load_in;
      CELL_FROM_LEFT:  ent_r <= left_in;
      CELL_FROM_RIGHT: ent_r <= right_in;
      CELL_AGE:        ent_r.aging <= sat_dec(ent_r.aging);
      CELL_HEAD: begin
        ent_r.aging     <= ent_r.next_prio;
        ent_r.next_prio <= sat_inc(ent_r.next_prio);
      end
      default: ;
    endcase
  end

  assign entry_o = ent_r;

endmodule

// ===== rtl/aps_rt_fifo.sv =====
// Shift-line FIFO of real-time process ids, head at position zero.
`timescale 1ns / 1ps

module aps_rt_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         pop,
  input  logic [7:0]                   din,
  output logic [7:0]                   head,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic                         full
);
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem_r [DEPTH];
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push) begin
      count_r <= count_r + 1'b1;
    end else if (pop) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push && CW'(i) == count_r) begin
        mem_r[i] <= din;
      end else if (pop && i < DEPTH - 1) begin
        mem_r[i] <= mem_r[i+1];
      end
    end
  end

  assign head  = mem_r[0];
  assign count = count_r;
  assign full  = (count_r == CW'(DEPTH));

endmodule

// ===== rtl/aging_priority_scheduler.sv =====
// Top level of the aging priority scheduler with a real-time FIFO and a sorting cell chain.
//
//   channel  | direction | payload
//   in_ch    | sink      | req_type, proc_id, priority_req
//   out_ch   | source    | status, chosen_id
//   cfg_ch   | sink      | realtime_priority
//
// Add, finish and real-time schedule requests go through S_POST to a registered result.
// A table schedule runs odd-even sort phases in the cell chain until consecutive phases
// make no swap, then ages the table in S_AGE and goes through S_POST.
// A new request is accepted while an earlier result still waits on out_ch.
// Reset clears the counts, the state machine and the output valid; no clearing pass.
`timescale 1ns / 1ps
`include "aging_priority_scheduler_assert.svh"

module aging_priority_scheduler #(
  parameter int RT_DEPTH    = 16,
  parameter int TABLE_DEPTH = 16
) (
  input logic   clk,
  input logic   rst_n,
  aps_in_if.sink    in_ch,
  aps_out_if.source out_ch,
  aps_cfg_if.sink   cfg_ch
);
  import aps_pkg::*;

  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int RCW = $clog2(RT_DEPTH + 1);

  sched_state_t       state_r, state_nxt;
  logic               phase_r, phase_nxt;
  logic               quiet_r, quiet_nxt;
  logic [CW-1:0]      entry_count_r, entry_count_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [7:0]         res_id_r, res_id_nxt;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [7:0]         out_id_r;
  logic signed [15:0] rt_prio_r;

  entry_t             ent [TABLE_DEPTH];
  cell_op_t           cell_op [TABLE_DEPTH];
  entry_t             new_entry;
  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] shift_mask;
  logic [TABLE_DEPTH-2:0] desc;
  logic [TABLE_DEPTH-2:0] sw;
  logic               any_found;
  logic               any_swap;
  logic               in_accept;
  logic               out_free;
  logic               table_add;

  logic               rt_push, rt_pop, rt_full;
  logic [7:0]         rt_head;
  logic [RCW-1:0]     rt_count;

  aps_rt_fifo #(.DEPTH(RT_DEPTH)) u_rt_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rt_push),
    .pop   (rt_pop),
    .din   (in_ch.proc_id),
    .head  (rt_head),
    .count (rt_count),
    .full  (rt_full)
  );

  assign new_entry.id        = in_ch.proc_id;
  assign new_entry.aging     = in_ch.priority_req;
  assign new_entry.next_prio = sat_inc(in_ch.priority_req);

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    aps_cell u_cell (
      .clk      (clk),
      .op       (cell_op[g]),
      .left_in  (ent[(g == 0) ? 0 : g - 1]),
      .right_in (ent[(g == TABLE_DEPTH - 1) ? g : g + 1]),
      .load_in  (new_entry),
      .entry_o  (ent[g])
    );
  end

  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign table_add   = in_accept && in_ch.req_type == REQ_ADD &&
                       in_ch.priority_req != rt_prio_r && entry_count_r != CW'(TABLE_DEPTH);

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      valid[i]      = CW'(i) < entry_count_r;
      seen          = seen || (valid[i] && ent[i].id == in_ch.proc_id);
      shift_mask[i] = seen;
    end
    any_found = seen;
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      desc[i] = valid[i+1] && (ent[i].aging > ent[i+1].aging);
      sw[i]   = desc[i] && (state_r == S_SORT) && (1'(i % 2) == phase_r);
    end
    any_swap = |sw;
  end

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    quiet_nxt       = quiet_r;
    entry_count_nxt = entry_count_r;
    res_status_nxt  = res_status_r;
    res_id_nxt      = res_id_r;
    rt_push         = 1'b0;
    rt_pop          = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_status_nxt = STAT_OK;
          res_id_nxt     = '0;
          state_nxt      = S_POST;
          case (in_ch.req_type)
            REQ_ADD: begin
              if (in_ch.priority_req == rt_prio_r) begin
                if (rt_full) begin
                  res_status_nxt = STAT_FULL;
                end else begin
                  rt_push = 1'b1;
                end
              end else if (entry_count_r == CW'(TABLE_DEPTH)) begin
                res_status_nxt = STAT_FULL;
              end else begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (CW'(i) == entry_count_r) begin
                    cell_op[i] = CELL_LOAD;
                  end
                end
                entry_count_nxt = entry_count_r + 1'b1;
              end
            end
            REQ_SCHED: begin
              if (rt_count != '0) begin
                res_id_nxt = rt_head;
              end else if (entry_count_r == '0) begin
                res_status_nxt = STAT_NONE;
              end else begin
                state_nxt = S_SORT;
                phase_nxt = 1'b0;
                quiet_nxt = 1'b0;
              end
            end
            REQ_FINISH: begin
              if (rt_count != '0 && rt_head == in_ch.proc_id) begin
                rt_pop = 1'b1;
              end else if (any_found) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (shift_mask[i]) begin
                    cell_op[i] = CELL_FROM_RIGHT;
                  end
                end
                entry_count_nxt = entry_count_r - 1'b1;
              end else begin
                res_status_nxt = STAT_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      S_SORT: begin
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
          if (sw[i]) begin
            cell_op[i]   = CELL_FROM_RIGHT;
            cell_op[i+1] = CELL_FROM_LEFT;
          end
        end
        phase_nxt = !phase_r;
        quiet_nxt = !any_swap;
        if (!any_swap && quiet_r) begin
          state_nxt = S_AGE;
        end
      end
      S_AGE: begin
        cell_op[0] = CELL_HEAD;
        for (int i = 1; i < TABLE_DEPTH; i++) begin
          cell_op[i] = CELL_AGE;
        end
        res_status_nxt = STAT_OK;
        res_id_nxt     = ent[0].id;
        state_nxt      = S_POST;
      end
      S_POST: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= 1'b0;
      quiet_r       <= 1'b0;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
      rt_prio_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      quiet_r       <= quiet_nxt;
      entry_count_r <= entry_count_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        rt_prio_r <= cfg_ch.realtime_priority;
      end
      if (state_r == S_POST && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    if (state_r == S_POST && out_free) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.chosen_id = out_id_r;

  `APS_ASSERT_NEXT(a_add_grows, table_add, entry_count_r == $past(entry_count_r) + 1'b1, "no add")
  `APS_ASSERT_IMPL(a_sorted_at_age, state_r == S_AGE, desc == '0, "table unsorted at aging")
  `APS_ASSERT_IMPL(a_out_from_post, $rose(out_valid_r), $past(state_r == S_POST), "stray result")

endmodule
